// ===== hw/rtl/signed_binary_to_decimal_ascii_core_assert.svh =====
// Assertion macros for the decimal ASCII converter core.
// Included by the top level; no other dependencies.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbda assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbda assertion failed");

`endif

// ===== hw/rtl/sbda_pkg.sv =====
// Shared types, constants and power-of-ten table for the decimal ASCII converter.
// No dependencies.
`timescale 1ns / 1ps

package sbda_pkg;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_MINUS   = 8'h2D;
  localparam logic [7:0] ASCII_NUL     = 8'h00;
  localparam logic [7:0] DECIMAL_RADIX = 8'd10;
  localparam logic [3:0] TOP_POW       = 4'd9;
  localparam int         SBDA_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [31:0] number;
    logic [7:0]         base_request;
  } sbda_in_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } sbda_out_t;

  // One classified request, ready for the digit sequencer.
  typedef struct packed {
    logic        bad_radix;
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  top_pow;
  } sbda_job_t;

  typedef struct packed {
    logic      valid;
    sbda_job_t job;
  } sbda_head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIGN,
    ST_DIGIT,
    ST_TERM
  } sbda_state_t;

  typedef struct packed {
    sbda_state_t state;
  } sbda_back_status_t;

  function automatic logic [33:0] pow10(input logic [3:0] p);
    logic [33:0] v;
    case (p)
      4'd0:    v = 34'd1;
      4'd1:    v = 34'd10;
      4'd2:    v = 34'd100;
      4'd3:    v = 34'd1000;
      4'd4:    v = 34'd10000;
      4'd5:    v = 34'd100000;
      4'd6:    v = 34'd1000000;
      4'd7:    v = 34'd10000000;
      4'd8:    v = 34'd100000000;
      4'd9:    v = 34'd1000000000;
      default: v = 34'd1;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/signed_binary_to_decimal_ascii_core.sv =====
// Channel   Handshake        Payload
// request   start / busy     in_payload  (number, base_request)
// result    out_strobe       out_payload (text_char, end_of_text)
//
// One character leaves per cycle; a request yields 1 to 12 characters, set by the
// single-character digit sequencer in the back end.
// A request's first character comes via the queue, sequencer state and output register.
// Reset (synchronous, active low) empties the queue and idles the sequencer.
// The receiver cannot stall; busy rises only while the request queue is full.
// Depends on sbda_pkg, sbda_front, sbda_queue, sbda_back and the assertion header.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_core_assert.svh"

module signed_binary_to_decimal_ascii_core import sbda_pkg::*; #(
  parameter int QUEUE_DEPTH = SBDA_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sbda_in_t  in_payload,
  output logic      out_strobe,
  output sbda_out_t out_payload
);

  sbda_job_t         front_job;
  sbda_head_t        head;
  logic              pop;
  logic              full;
  sbda_back_status_t back_status;

  assign busy = full;

  sbda_front u_front (
    .in_payload (in_payload),
    .job        (front_job)
  );

  sbda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (start),
    .push_job (front_job),
    .pop      (pop),
    .head     (head),
    .full     (full)
  );

  sbda_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .status      (back_status),
    .out_strobe  (out_strobe),
    .out_payload (out_payload)
  );

  `SBDA_ASSERT_NEXT(a_accept_queued, clk, rst_n, start && !busy, head.valid)
  `SBDA_ASSERT_NEXT(a_digit_emits, clk, rst_n, back_status.state == ST_DIGIT, out_strobe)
  `SBDA_ASSERT_NOW(a_text_continues, clk, rst_n, out_strobe && !out_payload.end_of_text,
                   back_status.state != ST_IDLE)
  `SBDA_ASSERT_NOW(a_pop_has_entry, clk, rst_n, pop, head.valid)

endmodule

// ===== hw/rtl/sbda_front.sv =====
// Front end: classifies a request and finds its magnitude and leading digit position.
// Depends on sbda_pkg.
`timescale 1ns / 1ps

module sbda_front import sbda_pkg::*; (
  input  sbda_in_t  in_payload,
  output sbda_job_t job
);

  logic [31:0] raw;
  logic [31:0] mag;
  logic [3:0]  top;

  assign raw = in_payload.number;
  assign mag = raw[31] ? (~raw + 32'd1) : raw;

  // Highest power of ten not above the magnitude; zero lands on the units place.
  always_comb begin
    top = 4'd0;
    for (int p = 1; p <= int'(TOP_POW); p++) begin
      if ({2'b00, mag} >= pow10(4'(p))) begin
        top = 4'(p);
      end
    end
  end

  always_comb begin
    job.bad_radix = (in_payload.base_request != DECIMAL_RADIX);
    job.neg       = raw[31];
    job.mag       = mag;
    job.top_pow   = top;
  end

endmodule

// ===== hw/rtl/sbda_queue.sv =====
// Short register queue between the front end and the digit sequencer.
// Depends on sbda_pkg.
`timescale 1ns / 1ps

module sbda_queue import sbda_pkg::*; #(
  parameter int DEPTH = SBDA_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  sbda_job_t  push_job,
  input  logic       pop,
  output sbda_head_t head,
  output logic       full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbda_job_t         entry_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.job   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/sbda_back.sv =====
// Back end: digit sequencer, one character per cycle into the output register.
// Depends on sbda_pkg.
`timescale 1ns / 1ps

module sbda_back import sbda_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sbda_head_t        head,
  output logic              pop,
  output sbda_back_status_t status,
  output logic              out_strobe,
  output sbda_out_t         out_payload
);

  sbda_state_t state_r, state_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic [3:0]  pow_r, pow_nxt;
  logic        strobe_r, strobe_nxt;
  sbda_out_t   payload_r, payload_nxt;

  logic [33:0] base;
  logic [33:0] sub;
  logic [3:0]  digit;

  // Digit at the current power: largest multiple of the power not above the remainder.
  always_comb begin
    base  = pow10(pow_r);
    digit = 4'd0;
    sub   = 34'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, mag_r} >= base * 34'(k)) begin
        digit = 4'(k);
        sub   = base * 34'(k);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    pow_nxt     = pow_r;
    pop         = 1'b0;
    strobe_nxt  = 1'b0;
    payload_nxt = payload_r;

    case (state_r)
      ST_SIGN: begin
        strobe_nxt              = 1'b1;
        payload_nxt.text_char   = ASCII_MINUS;
        payload_nxt.end_of_text = 1'b0;
        state_nxt               = ST_DIGIT;
      end
      ST_DIGIT: begin
        strobe_nxt              = 1'b1;
        payload_nxt.text_char   = ASCII_ZERO + {4'd0, digit};
        payload_nxt.end_of_text = 1'b0;
        mag_nxt                 = 32'({2'b00, mag_r} - sub);
        if (pow_r == 4'd0) begin
          state_nxt = ST_TERM;
        end else begin
          pow_nxt = pow_r - 4'd1;
        end
      end
      ST_TERM: begin
        strobe_nxt              = 1'b1;
        payload_nxt.text_char   = ASCII_NUL;
        payload_nxt.end_of_text = 1'b1;
        state_nxt               = ST_IDLE;
      end
      default: begin
      end
    endcase

    // Load the next request as soon as the sequencer is free or finishing.
    if ((state_r == ST_IDLE || state_r == ST_TERM) && head.valid) begin
      pop     = 1'b1;
      mag_nxt = head.job.mag;
      pow_nxt = head.job.top_pow;
      if (head.job.bad_radix) begin
        state_nxt = ST_TERM;
      end else if (head.job.neg) begin
        state_nxt = ST_SIGN;
      end else begin
        state_nxt = ST_DIGIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    pow_r     <= pow_nxt;
    payload_r <= payload_nxt;
  end

  assign status.state = state_r;
  assign out_strobe   = strobe_r;
  assign out_payload  = payload_r;

endmodule
